>>> hw/rtl/stack_sample_segment_merger_assert.svh
// Assertion helpers for the segment merger.
`ifndef STACK_SAMPLE_SEGMENT_MERGER_ASSERT_SVH
`define STACK_SAMPLE_SEGMENT_MERGER_ASSERT_SVH

// Invariant that holds at every edge out of reset.
`define SSM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define SSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ssm_pkg.sv
`default_nettype none

package ssm_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int COUNT_WIDTH = 32;

    localparam int IDX_W       = $clog2(MAX_DEPTH);
    localparam int POS_W       = $clog2(MAX_DEPTH + 1);
    localparam int TS_W        = 64;
    localparam int ID_W        = 32;
    localparam int DUR_W       = 63;
    localparam int SEG_DEPTH_W = 6;
    localparam int SAMPLES_W   = 32;
    localparam int KIND_W      = 2;
    localparam int REQ_W       = 2;

    // request types
    localparam logic [REQ_W-1:0] REQ_FRAME = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EMPTY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SEG       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIME_BACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_DEEP  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FLUSH,
        ST_ERROR
    } seq_state_t;

    typedef struct packed {
        logic [ID_W-1:0]        frame;
        logic [TS_W-1:0]        start;
        logic [COUNT_WIDTH-1:0] samples;
    } entry_t;

    typedef struct packed {
        logic             shift_down;  // push: every cell takes its upper neighbor
        logic             shift_up;    // pop: every cell takes its lower neighbor
        logic             inc;         // selected cell bumps its sample count
        logic [IDX_W-1:0] target;
        logic [ID_W-1:0]  id;
    } cell_ctrl_t;

    typedef struct packed {
        logic             halted;
        logic [POS_W-1:0] open_count;
    } seq_status_t;

    // end - start, clamped to [0, 2^63-1]
    function automatic logic [DUR_W-1:0] seg_dur(logic [TS_W-1:0] end_time,
                                                 logic [TS_W-1:0] start_time);
        logic [TS_W:0]      diff;
        logic [DUR_W-1:0]   res;
        diff = {end_time[TS_W-1], end_time} - {start_time[TS_W-1], start_time};
        if (diff[TS_W])
            res = '0;
        else if (diff[TS_W-1])
            res = '1;
        else
            res = diff[DUR_W-1:0];
        return res;
    endfunction

    function automatic logic [SEG_DEPTH_W-1:0] to_seg_depth(logic [POS_W-1:0] pos);
        logic [POS_W+SEG_DEPTH_W-1:0] w;
        w = {{SEG_DEPTH_W{1'b0}}, pos};
        return w[SEG_DEPTH_W-1:0];
    endfunction

    function automatic logic [SAMPLES_W-1:0] to_samples(logic [COUNT_WIDTH-1:0] cnt);
        logic [COUNT_WIDTH+SAMPLES_W-1:0] w;
        w = {{SAMPLES_W{1'b0}}, cnt};
        return w[SAMPLES_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssm_cell.sv
`default_nettype none

module ssm_cell (
    input  wire logic                      clk,
    input  wire logic [ssm_pkg::IDX_W-1:0] cell_idx,
    input  wire ssm_pkg::cell_ctrl_t       ctrl,
    input  wire ssm_pkg::entry_t           from_above,
    input  wire ssm_pkg::entry_t           from_below,
    output ssm_pkg::entry_t                entry,
    output logic                           hit
);

    ssm_pkg::entry_t entry_reg;
    ssm_pkg::entry_t entry_next;
    logic            sel;

    assign sel   = (cell_idx == ctrl.target);
    assign hit   = sel && (entry_reg.frame == ctrl.id);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_down)
        begin
            entry_next = from_above;
        end
        else if (ctrl.shift_up)
        begin
            entry_next = from_below;
        end
        else if (ctrl.inc && sel && (entry_reg.samples != '1))
        begin
            entry_next.samples = entry_reg.samples + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/ssm_seq.sv
`default_nettype none

module ssm_seq (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [ssm_pkg::REQ_W-1:0]       req_type,
    input  wire logic signed [ssm_pkg::TS_W-1:0] timestamp,
    input  wire logic [ssm_pkg::ID_W-1:0]        frame_id,
    input  wire logic                            last_frame,
    // cell chain
    input  wire logic                            hit_any,
    input  wire ssm_pkg::entry_t                 top_entry,
    input  wire ssm_pkg::entry_t                 tail_entry,
    output ssm_pkg::cell_ctrl_t                  ctrl,
    output ssm_pkg::entry_t                      new_entry,
    output ssm_pkg::seq_status_t                 status,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [ssm_pkg::KIND_W-1:0]           result_kind,
    output logic signed [ssm_pkg::TS_W-1:0]      seg_start,
    output logic [ssm_pkg::DUR_W-1:0]            seg_duration,
    output logic [ssm_pkg::SEG_DEPTH_W-1:0]      seg_depth,
    output logic [ssm_pkg::ID_W-1:0]             seg_id,
    output logic [ssm_pkg::SAMPLES_W-1:0]        seg_samples,
    output logic                                 last_result
);

    ssm_pkg::seq_state_t state_reg, state_next;

    logic [ssm_pkg::POS_W-1:0]  open_count_reg, open_count_next;
    logic [ssm_pkg::POS_W-1:0]  fp_reg, fp_next;
    logic                       diverged_reg, diverged_next;
    logic [ssm_pkg::TS_W-1:0]   sample_time_reg, sample_time_next;
    logic [ssm_pkg::TS_W-1:0]   prev_time_reg, prev_time_next;
    logic                       seen_reg, seen_next;
    logic                       halted_reg, halted_next;
    logic [ssm_pkg::POS_W-1:0]  pop_limit_reg, pop_limit_next;
    logic                       pend_push_reg, pend_push_next;
    logic [ssm_pkg::ID_W-1:0]   push_id_reg, push_id_next;
    logic [ssm_pkg::POS_W-1:0]  gap_reg, gap_next;
    logic [ssm_pkg::POS_W-1:0]  flush_depth_reg, flush_depth_next;
    logic [ssm_pkg::KIND_W-1:0] err_kind_reg, err_kind_next;

    logic                            out_valid_reg, out_valid_next;
    logic [ssm_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [ssm_pkg::TS_W-1:0]        start_reg, start_next;
    logic [ssm_pkg::DUR_W-1:0]       dur_reg, dur_next;
    logic [ssm_pkg::SEG_DEPTH_W-1:0] depth_reg, depth_next;
    logic [ssm_pkg::ID_W-1:0]        id_reg, id_next;
    logic [ssm_pkg::SAMPLES_W-1:0]   samples_reg, samples_next;
    logic                            last_reg, last_next;

    // decode
    logic                      in_accept;
    logic                      out_free;
    logic                      first_frame;
    logic                      ts_ok;
    logic                      div_eff;
    logic                      matched;
    logic                      need_pops;
    logic                      tail_pops;
    logic [ssm_pkg::POS_W-1:0] fp_inc;
    logic [ssm_pkg::POS_W-1:0] tgt_full;
    logic [ssm_pkg::POS_W-1:0] top_depth;
    logic [ssm_pkg::TS_W-1:0]  st_eff;
    logic                      do_empty;
    logic                      do_flush;
    logic                      do_frame;
    logic                      frame_terr;
    logic                      frame_deep;
    logic                      frame_ok;
    logic                      empty_terr;
    logic                      pop_done;

    always_comb
    begin
        in_accept   = in_valid && (state_reg == ssm_pkg::ST_IDLE);
        out_free    = !out_valid_reg || !out_stall;
        first_frame = (fp_reg == '0);
        ts_ok       = !seen_reg || ($signed(timestamp) >= $signed(prev_time_reg));
        div_eff     = first_frame ? 1'b0 : diverged_reg;
        fp_inc      = fp_reg + 1'b1;
        matched     = !div_eff && (fp_reg < open_count_reg) && hit_any;
        need_pops   = !div_eff && (open_count_reg > fp_reg);
        tail_pops   = (open_count_reg > fp_inc);
        tgt_full    = open_count_reg - fp_reg - 1'b1;
        top_depth   = open_count_reg - 1'b1;
        st_eff      = first_frame ? timestamp : sample_time_reg;
        do_empty    = in_accept && !halted_reg && (req_type == ssm_pkg::REQ_EMPTY);
        do_flush    = in_accept && !halted_reg && (req_type == ssm_pkg::REQ_FLUSH);
        do_frame    = in_accept && !halted_reg && (req_type == ssm_pkg::REQ_FRAME);
        frame_terr  = do_frame && first_frame && !ts_ok;
        frame_deep  = do_frame && !frame_terr
                      && (fp_reg >= ssm_pkg::POS_W'(ssm_pkg::MAX_DEPTH));
        frame_ok    = do_frame && !frame_terr && !frame_deep;
        empty_terr  = do_empty && !ts_ok;
        pop_done    = (open_count_reg == pop_limit_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                if (frame_terr || frame_deep || empty_terr)
                    state_next = ssm_pkg::ST_ERROR;
                else if (do_flush && (open_count_reg != '0))
                    state_next = ssm_pkg::ST_FLUSH;
                else if (frame_ok && matched && last_frame && tail_pops)
                    state_next = ssm_pkg::ST_POP;
                else if (frame_ok && !matched && need_pops)
                    state_next = ssm_pkg::ST_POP;
            end
            ssm_pkg::ST_POP:
            begin
                if (pop_done)
                    state_next = ssm_pkg::ST_IDLE;
            end
            ssm_pkg::ST_FLUSH:
            begin
                if ((gap_reg == '0) && out_free && (open_count_reg == ssm_pkg::POS_W'(1)))
                    state_next = ssm_pkg::ST_IDLE;
            end
            ssm_pkg::ST_ERROR:
            begin
                if (out_free)
                    state_next = ssm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and chain control
    always_comb
    begin
        open_count_next  = open_count_reg;
        fp_next          = fp_reg;
        diverged_next    = diverged_reg;
        sample_time_next = sample_time_reg;
        prev_time_next   = prev_time_reg;
        seen_next        = seen_reg;
        halted_next      = halted_reg;
        pop_limit_next   = pop_limit_reg;
        pend_push_next   = pend_push_reg;
        push_id_next     = push_id_reg;
        gap_next         = gap_reg;
        flush_depth_next = flush_depth_reg;
        err_kind_next    = err_kind_reg;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        start_next     = start_reg;
        dur_next       = dur_reg;
        depth_next     = depth_reg;
        id_next        = id_reg;
        samples_next   = samples_reg;
        last_next      = last_reg;

        ctrl.shift_down = 1'b0;
        ctrl.shift_up   = 1'b0;
        ctrl.inc        = 1'b0;
        ctrl.target     = tgt_full[ssm_pkg::IDX_W-1:0];
        ctrl.id         = frame_id;

        new_entry.frame   = push_id_reg;
        new_entry.start   = sample_time_reg;
        new_entry.samples = ssm_pkg::COUNT_WIDTH'(1);

        unique case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                if (do_empty)
                begin
                    fp_next       = '0;
                    diverged_next = 1'b0;
                    if (ts_ok)
                    begin
                        prev_time_next = timestamp;
                        seen_next      = 1'b1;
                    end
                    else
                    begin
                        halted_next   = 1'b1;
                        err_kind_next = ssm_pkg::KIND_TIME_BACK;
                    end
                end
                if (do_flush)
                begin
                    fp_next          = '0;
                    diverged_next    = 1'b0;
                    gap_next         = ssm_pkg::POS_W'(ssm_pkg::MAX_DEPTH) - open_count_reg;
                    flush_depth_next = '0;
                end
                if (frame_terr)
                begin
                    halted_next   = 1'b1;
                    err_kind_next = ssm_pkg::KIND_TIME_BACK;
                end
                else if (do_frame)
                begin
                    if (first_frame)
                    begin
                        prev_time_next   = timestamp;
                        seen_next        = 1'b1;
                        sample_time_next = timestamp;
                    end
                    if (frame_deep)
                    begin
                        halted_next   = 1'b1;
                        err_kind_next = ssm_pkg::KIND_TOO_DEEP;
                    end
                    else if (matched)
                    begin
                        ctrl.inc       = 1'b1;
                        fp_next        = last_frame ? '0 : fp_inc;
                        diverged_next  = 1'b0;
                        pop_limit_next = fp_inc;
                        pend_push_next = 1'b0;
                    end
                    else
                    begin
                        fp_next        = last_frame ? '0 : fp_inc;
                        diverged_next  = !last_frame;
                        pop_limit_next = fp_reg;
                        if (need_pops)
                        begin
                            pend_push_next = 1'b1;
                            push_id_next   = frame_id;
                        end
                        else
                        begin
                            ctrl.shift_down = 1'b1;
                            new_entry.frame = frame_id;
                            new_entry.start = st_eff;
                            open_count_next = fp_inc;
                        end
                    end
                end
            end
            ssm_pkg::ST_POP:
            begin
                if (pop_done)
                begin
                    if (pend_push_reg)
                    begin
                        ctrl.shift_down = 1'b1;
                        open_count_next = pop_limit_reg + 1'b1;
                        pend_push_next  = 1'b0;
                    end
                end
                else if (out_free)
                begin
                    ctrl.shift_up   = 1'b1;
                    open_count_next = top_depth;
                    out_valid_next  = 1'b1;
                    kind_next       = ssm_pkg::KIND_SEG;
                    start_next      = top_entry.start;
                    dur_next        = ssm_pkg::seg_dur(sample_time_reg, top_entry.start);
                    depth_next      = ssm_pkg::to_seg_depth(top_depth);
                    id_next         = top_entry.frame;
                    samples_next    = ssm_pkg::to_samples(top_entry.samples);
                    last_next       = (top_depth == pop_limit_reg);
                end
            end
            ssm_pkg::ST_FLUSH:
            begin
                if (gap_reg != '0)
                begin
                    ctrl.shift_down = 1'b1;
                    gap_next        = gap_reg - 1'b1;
                end
                else if (out_free)
                begin
                    ctrl.shift_down  = 1'b1;
                    open_count_next  = top_depth;
                    flush_depth_next = flush_depth_reg + 1'b1;
                    out_valid_next   = 1'b1;
                    kind_next        = ssm_pkg::KIND_SEG;
                    start_next       = tail_entry.start;
                    dur_next         = ssm_pkg::seg_dur(prev_time_reg, tail_entry.start);
                    depth_next       = ssm_pkg::to_seg_depth(flush_depth_reg);
                    id_next          = tail_entry.frame;
                    samples_next     = ssm_pkg::to_samples(tail_entry.samples);
                    last_next        = (open_count_reg == ssm_pkg::POS_W'(1));
                end
            end
            ssm_pkg::ST_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = err_kind_reg;
                    start_next     = '0;
                    dur_next       = '0;
                    depth_next     = '0;
                    id_next        = '0;
                    samples_next   = '0;
                    last_next      = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ssm_pkg::ST_IDLE;
            open_count_reg  <= '0;
            fp_reg          <= '0;
            diverged_reg    <= 1'b0;
            sample_time_reg <= '0;
            prev_time_reg   <= '0;
            seen_reg        <= 1'b0;
            halted_reg      <= 1'b0;
            pop_limit_reg   <= '0;
            pend_push_reg   <= 1'b0;
            gap_reg         <= '0;
            flush_depth_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            open_count_reg  <= open_count_next;
            fp_reg          <= fp_next;
            diverged_reg    <= diverged_next;
            sample_time_reg <= sample_time_next;
            prev_time_reg   <= prev_time_next;
            seen_reg        <= seen_next;
            halted_reg      <= halted_next;
            pop_limit_reg   <= pop_limit_next;
            pend_push_reg   <= pend_push_next;
            gap_reg         <= gap_next;
            flush_depth_reg <= flush_depth_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        push_id_reg  <= push_id_next;
        err_kind_reg <= err_kind_next;
        kind_reg     <= kind_next;
        start_reg    <= start_next;
        dur_reg      <= dur_next;
        depth_reg    <= depth_next;
        id_reg       <= id_next;
        samples_reg  <= samples_next;
        last_reg     <= last_next;
    end

    assign in_stall          = (state_reg != ssm_pkg::ST_IDLE);
    assign status.halted     = halted_reg;
    assign status.open_count = open_count_reg;

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign seg_start    = start_reg;
    assign seg_duration = dur_reg;
    assign seg_depth    = depth_reg;
    assign seg_id       = id_reg;
    assign seg_samples  = samples_reg;
    assign last_result  = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/stack_sample_segment_merger.sv
// Channel  Dir  Handshake             Fields
// request  in   in_valid, in_stall    req_type, timestamp, frame_id, last_frame
// result   out  out_valid, out_stall  result_kind .. last_result (seven fields)
//
// A matching frame, or one that opens a segment without closing any, is done on accept;
// a frame that closes segments pops them one at a time in the pop state, then leaves it,
// where a diverging frame pushes. A flush with segments open walks the outermost entry
// to the tail, then hands segments out from the tail, outermost first. Reset is
// asynchronous and clears control only; a stalled result stalls the chain, and with
// it the request side, as soon as another result is due.
`default_nettype none

module stack_sample_segment_merger (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [ssm_pkg::REQ_W-1:0]       req_type,
    input  wire logic signed [ssm_pkg::TS_W-1:0] timestamp,
    input  wire logic [ssm_pkg::ID_W-1:0]        frame_id,
    input  wire logic                            last_frame,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [ssm_pkg::KIND_W-1:0]           result_kind,
    output logic signed [ssm_pkg::TS_W-1:0]      seg_start,
    output logic [ssm_pkg::DUR_W-1:0]            seg_duration,
    output logic [ssm_pkg::SEG_DEPTH_W-1:0]      seg_depth,
    output logic [ssm_pkg::ID_W-1:0]             seg_id,
    output logic [ssm_pkg::SAMPLES_W-1:0]        seg_samples,
    output logic                                 last_result
);

`include "stack_sample_segment_merger_assert.svh"

    // The open-segment stack lives in a chain of cells, top of stack in cell 0.
    // Depth of cell i is open_count - 1 - i. Push shifts toward the tail,
    // pop shifts toward cell 0; the sequencer reads cell 0 on pops and the
    // tail cell on flush.
    ssm_pkg::entry_t             entries [ssm_pkg::MAX_DEPTH];
    logic [ssm_pkg::MAX_DEPTH-1:0] hits;
    logic                        hit_any;
    ssm_pkg::cell_ctrl_t         ctrl;
    ssm_pkg::entry_t             new_entry;
    ssm_pkg::seq_status_t        status;

    genvar i;
    generate
        for (i = 0; i < ssm_pkg::MAX_DEPTH; i++)
        begin : g_cell
            ssm_pkg::entry_t above;
            ssm_pkg::entry_t below;

            if (i == 0)
            begin : g_head
                assign above = new_entry;
            end
            else
            begin : g_mid_above
                assign above = entries[i-1];
            end

            if (i == ssm_pkg::MAX_DEPTH - 1)
            begin : g_tail
                assign below = entries[i];
            end
            else
            begin : g_mid_below
                assign below = entries[i+1];
            end

            ssm_cell u_cell (
                .clk        (clk),
                .cell_idx   (ssm_pkg::IDX_W'(i)),
                .ctrl       (ctrl),
                .from_above (above),
                .from_below (below),
                .entry      (entries[i]),
                .hit        (hits[i])
            );
        end
    endgenerate

    // only the cell at the requested depth can report a hit
    assign hit_any = |hits;

    ssm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .timestamp    (timestamp),
        .frame_id     (frame_id),
        .last_frame   (last_frame),
        .hit_any      (hit_any),
        .top_entry    (entries[0]),
        .tail_entry   (entries[ssm_pkg::MAX_DEPTH-1]),
        .ctrl         (ctrl),
        .new_entry    (new_entry),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .seg_start    (seg_start),
        .seg_duration (seg_duration),
        .seg_depth    (seg_depth),
        .seg_id       (seg_id),
        .seg_samples  (seg_samples),
        .last_result  (last_result)
    );

    `SSM_ASSERT_ALWAYS(a_one_hit, clk, rst_n, $onehot0(hits), "more than one cell hit")
    `SSM_ASSERT_ALWAYS(a_depth_bound, clk, rst_n,
        status.open_count <= ssm_pkg::POS_W'(ssm_pkg::MAX_DEPTH),
        "open segment count beyond stack size")
    `SSM_ASSERT_NEXT(a_halt_sticky, clk, rst_n, status.halted, status.halted,
        "halt cleared without reset")
    `SSM_ASSERT_IMPLY(a_err_last, clk, rst_n,
        out_valid && (result_kind != ssm_pkg::KIND_SEG), last_result,
        "error result not marked last")

endmodule

`default_nettype wire

>>> bench/segment_merge_checker.sv
`default_nettype none

// Watches both channels of the segment merger, keeps its own copy of the
// open-segment stack and compares every accepted result with the oldest
// prediction still waiting.
module segment_merge_checker
    import ssm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [REQ_W-1:0]       req_type,
    input  wire logic [TS_W-1:0]        timestamp,
    input  wire logic [ID_W-1:0]        frame_id,
    input  wire logic                   last_frame,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [KIND_W-1:0]      result_kind,
    input  wire logic [TS_W-1:0]        seg_start,
    input  wire logic [DUR_W-1:0]       seg_duration,
    input  wire logic [SEG_DEPTH_W-1:0] seg_depth,
    input  wire logic [ID_W-1:0]        seg_id,
    input  wire logic [SAMPLES_W-1:0]   seg_samples,
    input  wire logic                   last_result,
    output int                          mismatches,
    output int                          backlog
);

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [TS_W-1:0]        start;
        logic [DUR_W-1:0]       span;
        logic [SEG_DEPTH_W-1:0] depth;
        logic [ID_W-1:0]        id;
        logic [SAMPLES_W-1:0]   samples;
        logic                   last;
    } seg_result_t;

    // open-segment stack, index 0 outermost
    logic [ID_W-1:0]        open_id   [MAX_DEPTH];
    logic [TS_W-1:0]        open_from [MAX_DEPTH];
    logic [COUNT_WIDTH-1:0] open_hits [MAX_DEPTH];
    int                     depth_open;
    int                     frame_at;
    bit                     branched;
    bit                     any_sample;
    bit                     stopped;
    logic [TS_W-1:0]        stamp_now;
    logic [TS_W-1:0]        stamp_prev;

    seg_result_t due_results [$];
    seg_result_t want;
    int          results_seen;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t, result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    function automatic seg_result_t closed_segment(input int d, input logic [TS_W-1:0] end_t);
        seg_result_t          r;
        logic signed [TS_W:0] gap;
        gap = $signed({end_t[TS_W-1], end_t}) - $signed({open_from[d][TS_W-1], open_from[d]});
        r = '0;
        r.kind = KIND_SEG;
        r.start = open_from[d];
        if (gap < 0)
            r.span = '0;
        else if (gap[TS_W-1])
            r.span = '1;   // too long for 63 bits
        else
            r.span = gap[DUR_W-1:0];
        r.depth = SEG_DEPTH_W'(d);
        r.id = open_id[d];
        r.samples = SAMPLES_W'(open_hits[d]);
        return r;
    endfunction

    function automatic seg_result_t fault(input logic [KIND_W-1:0] k);
        seg_result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    // time may stand still but not go back
    function automatic bit stamp_in_order(input logic [TS_W-1:0] ts);
        if (any_sample && $signed(ts) < $signed(stamp_prev))
            return 1'b0;
        stamp_prev = ts;
        any_sample = 1'b1;
        return 1'b1;
    endfunction

    task automatic absorb_request(input logic [REQ_W-1:0] rt, input logic [TS_W-1:0] ts,
                                  input logic [ID_W-1:0] id, input logic lf);
        seg_result_t batch [MAX_DEPTH+1];
        int          n;
        int          d;
        n = 0;
        if (stopped)
            return;
        case (rt)
            REQ_EMPTY:
            begin
                frame_at = 0;
                branched = 1'b0;
                if (!stamp_in_order(ts))
                begin
                    stopped = 1'b1;
                    batch[n] = fault(KIND_TIME_BACK);
                    n++;
                end
            end
            REQ_FLUSH:
            begin
                for (d = 0; d < depth_open; d++)
                begin
                    batch[n] = closed_segment(d, stamp_prev);
                    n++;
                end
                depth_open = 0;
                frame_at = 0;
                branched = 1'b0;
            end
            REQ_FRAME:
            begin
                if (frame_at == 0)
                begin
                    if (!stamp_in_order(ts))
                    begin
                        stopped = 1'b1;
                        batch[n] = fault(KIND_TIME_BACK);
                        n++;
                    end
                    else
                    begin
                        stamp_now = ts;
                        branched = 1'b0;
                    end
                end
                if (!stopped && frame_at >= MAX_DEPTH)
                begin
                    stopped = 1'b1;
                    batch[n] = fault(KIND_TOO_DEEP);
                    n++;
                end
                if (!stopped)
                begin
                    d = frame_at;
                    if (!branched && d < depth_open && open_id[d] == id)
                    begin
                        if (open_hits[d] != '1)
                            open_hits[d]++;
                    end
                    else
                    begin
                        if (!branched)
                        begin
                            while (depth_open > d)
                            begin
                                depth_open--;
                                batch[n] = closed_segment(depth_open, stamp_now);
                                n++;
                            end
                            branched = 1'b1;
                        end
                        open_id[d] = id;
                        open_from[d] = stamp_now;
                        open_hits[d] = 1;
                        depth_open = d + 1;
                    end
                    frame_at = d + 1;
                    if (lf)
                    begin
                        // a shorter stack closes what lies below it
                        while (depth_open > frame_at)
                        begin
                            depth_open--;
                            batch[n] = closed_segment(depth_open, stamp_now);
                            n++;
                        end
                        frame_at = 0;
                        branched = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (n > 0)
            batch[n-1].last = 1'b1;
        for (d = 0; d < n; d++)
            due_results = {due_results, batch[d]};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_open = 0;
            frame_at = 0;
            branched = 1'b0;
            any_sample = 1'b0;
            stopped = 1'b0;
            stamp_now = '0;
            stamp_prev = '0;
            due_results.delete();
            mismatches = 0;
            backlog = 0;
            results_seen = 0;
        end
        else
        begin
            // predict first: a result in the same edge still belongs to an older request
            if (in_valid && !in_stall)
                absorb_request(req_type, timestamp, frame_id, last_frame);
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, kind %0d id %h",
                                              result_kind, seg_id));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result_kind !== want.kind)
                        report_mismatch($sformatf("result_kind %0d, want %0d",
                                                  result_kind, want.kind));
                    if (seg_start !== want.start)
                        report_mismatch($sformatf("seg_start %h, want %h",
                                                  seg_start, want.start));
                    if (seg_duration !== want.span)
                        report_mismatch($sformatf("seg_duration %h, want %h",
                                                  seg_duration, want.span));
                    if (seg_depth !== want.depth)
                        report_mismatch($sformatf("seg_depth %0d, want %0d",
                                                  seg_depth, want.depth));
                    if (seg_id !== want.id)
                        report_mismatch($sformatf("seg_id %h, want %h", seg_id, want.id));
                    if (seg_samples !== want.samples)
                        report_mismatch($sformatf("seg_samples %0d, want %0d",
                                                  seg_samples, want.samples));
                    if (last_result !== want.last)
                        report_mismatch($sformatf("last_result %b, want %b",
                                                  last_result, want.last));
                end
                results_seen++;
            end
            backlog = due_results.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/stack_sample_segment_merger_tb.sv
`default_nettype none

// Top of the segment merger bench. This module only makes requests, paces
// both channels and gives the verdict; segment_merge_checker does all the
// prediction and comparison and hands back its mismatch count and the number
// of results it still waits for.
module stack_sample_segment_merger_tb;
    import ssm_pkg::*;

    // request type the block must drop without a trace
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [TS_W-1:0] TS_MIN  = {1'b1, {(TS_W-1){1'b0}}};
    localparam logic signed [TS_W-1:0] TS_MAX  = {1'b0, {(TS_W-1){1'b1}}};
    localparam logic signed [TS_W-1:0] TS_BASE = 64'sh4000_0000_0000_0000;

    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int PHASE_ITEMS  = 25;    // counted requests per random phase
    // leave room for four flushes to finish
    localparam int DRAIN_CYCLES = 4 * (MAX_DEPTH + 1);

    typedef enum int
    {
        PACE_STEADY,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic [REQ_W-1:0]       req_type   = REQ_FRAME;
    logic signed [TS_W-1:0] timestamp  = '0;
    logic [ID_W-1:0]        frame_id   = '0;
    logic                   last_frame = 1'b0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [KIND_W-1:0]      result_kind;
    logic signed [TS_W-1:0] seg_start;
    logic [DUR_W-1:0]       seg_duration;
    logic [SEG_DEPTH_W-1:0] seg_depth;
    logic [ID_W-1:0]        seg_id;
    logic [SAMPLES_W-1:0]   seg_samples;
    logic                   last_result;

    int mismatches;
    int backlog;

    pace_t pace          = PACE_STEADY;
    bit    hold_request  = 1'b0;   // written by the request side only
    bit    hold_served   = 1'b0;   // written by the receiver only

    // the call stack the sender is currently walking, outermost first
    logic [ID_W-1:0]        stack_ids [MAX_DEPTH];
    int                     stack_len = 0;
    logic signed [TS_W-1:0] now_stamp = '0;
    int                     offered   = 0;

    always #5 clk = ~clk;

    stack_sample_segment_merger dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .timestamp    (timestamp),
        .frame_id     (frame_id),
        .last_frame   (last_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .seg_start    (seg_start),
        .seg_duration (seg_duration),
        .seg_depth    (seg_depth),
        .seg_id       (seg_id),
        .seg_samples  (seg_samples),
        .last_result  (last_result)
    );

    segment_merge_checker seg_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .timestamp    (timestamp),
        .frame_id     (frame_id),
        .last_frame   (last_frame),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .seg_start    (seg_start),
        .seg_duration (seg_duration),
        .seg_depth    (seg_depth),
        .seg_id       (seg_id),
        .seg_samples  (seg_samples),
        .last_result  (last_result),
        .mismatches   (mismatches),
        .backlog      (backlog)
    );

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random stall per cycle by pace, plus one long hold-off that
    // lets the block back up into its request side.
    initial
    begin
        int stall_pct;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                case (pace)
                    PACE_RECEIVER_STALLS: stall_pct = 82;
                    PACE_BOTH:            stall_pct = 37;
                    default:              stall_pct = 0;
                endcase
                out_stall <= int'($urandom_range(0, 99)) < stall_pct;
            end
        end
    end

    // Offer one request; called at a falling edge, returns at one. Gaps are
    // rolled before valid goes up, so valid never looks at stall, and valid
    // stays high straight into the next request when no gap is rolled.
    task automatic push_req(input logic [REQ_W-1:0] kind, input logic signed [TS_W-1:0] ts,
                            input logic [ID_W-1:0] id, input logic lf);
        int gap_pct;
        case (pace)
            PACE_SENDER_GAPS: gap_pct = 82;
            PACE_BOTH:        gap_pct = 37;
            default:          gap_pct = 0;
        endcase
        while (int'($urandom_range(0, 99)) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        timestamp  <= ts;
        frame_id   <= id;
        last_frame <= lf;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (kind != REQ_UNUSED)
            offered++;
    endtask

    // mostly a small pool of ids so that stacks share frames
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) < 7)
            return ID_W'($urandom_range(1, 12));
        return $urandom();
    endfunction

    // timestamp bits on non-leading frames are don't-care; toggle them all
    function automatic logic signed [TS_W-1:0] rand_stamp();
        return {$urandom(), $urandom()};
    endfunction

    // sample times never go backwards until the closing error
    function automatic logic signed [TS_W-1:0] next_stamp();
        if ($urandom_range(0, 3) != 0)
            now_stamp = now_stamp + TS_W'($urandom_range(1, 5000));
        return now_stamp;
    endfunction

    // Keep a prefix of the previous stack and grow a new tail; this gives
    // matches, divergences and shorter stacks. A rare deep stack can reach the
    // full depth.
    task automatic reshape_stack();
        int keep;
        int grow;
        int i;
        if ($urandom_range(0, 9) < 3)
            keep = stack_len;
        else
            keep = int'($urandom_range(0, stack_len));
        if ($urandom_range(0, 99) < 5)
            grow = int'($urandom_range(0, MAX_DEPTH - keep));
        else
            grow = int'($urandom_range(0, 3));
        if (keep + grow > MAX_DEPTH)
            grow = MAX_DEPTH - keep;
        if (keep + grow == 0)
            grow = 1;
        for (i = keep; i < keep + grow; i++)
            stack_ids[i] = pick_id();
        stack_len = keep + grow;
    endtask

    task automatic send_stack(input bit closed);
        int i;
        for (i = 0; i < stack_len; i++)
            push_req(REQ_FRAME, (i == 0) ? next_stamp() : rand_stamp(), stack_ids[i],
                     closed && i == stack_len - 1);
    endtask

    // Mostly whole samples; the rest empty samples, flushes, cut-off samples
    // and requests of an unused type.
    task automatic random_activity();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 80)
        begin
            reshape_stack();
            send_stack(1'b1);
        end
        else if (roll < 87)
        begin
            push_req(REQ_EMPTY, next_stamp(), pick_id(), $urandom_range(0, 1) == 1);
        end
        else if (roll < 92)
        begin
            push_req(REQ_FLUSH, rand_stamp(), pick_id(), $urandom_range(0, 1) == 1);
            stack_len = 0;
        end
        else if (roll < 96)
        begin
            // sample cut short, then ended by an empty sample or a flush
            reshape_stack();
            stack_len = int'($urandom_range(1, stack_len));
            send_stack(1'b0);
            if ($urandom_range(0, 1) == 1)
            begin
                push_req(REQ_EMPTY, next_stamp(), pick_id(), $urandom_range(0, 1) == 1);
            end
            else
            begin
                push_req(REQ_FLUSH, rand_stamp(), pick_id(), $urandom_range(0, 1) == 1);
                stack_len = 0;
            end
        end
        else
        begin
            push_req(REQ_UNUSED, rand_stamp(), pick_id(), $urandom_range(0, 1) == 1);
        end
    endtask

    // sender holds still until every predicted result is out
    task automatic drain();
        in_valid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input pace_t p);
        int first;
        pace = p;
        first = offered;
        while (offered - first < PHASE_ITEMS)
            random_activity();
        drain();
    endtask

    initial
    begin
        int i;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed requests, no idling ----
        // flush before any sample: nothing open, nothing out
        push_req(REQ_FLUSH, '0, '0, 1'b0);
        // unused request type is dropped
        push_req(REQ_UNUSED, rand_stamp(), $urandom(), 1'b1);
        // lowest time, extreme ids; then the same stack again at the same time
        push_req(REQ_FRAME, TS_MIN, 32'h0000_0000, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'hFFFF_FFFF, 1'b1);
        push_req(REQ_FRAME, TS_MIN, 32'h0000_0000, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'hFFFF_FFFF, 1'b1);
        // one frame deeper
        push_req(REQ_FRAME, 0, 32'h0000_0000, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'hFFFF_FFFF, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'd5, 1'b1);
        // shorter stack: both deeper segments close, deepest first
        push_req(REQ_FRAME, 10, 32'h0000_0000, 1'b1);
        // opens two new levels without closing anything
        push_req(REQ_FRAME, 20, 32'h0000_0000, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'd7, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'd8, 1'b1);
        // diverges at depth 1; the same id below it still reopens
        push_req(REQ_FRAME, 30, 32'h0000_0000, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'd9, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'd8, 1'b1);
        // empty sample cuts a sample short
        push_req(REQ_FRAME, 40, 32'h0000_0000, 1'b0);
        push_req(REQ_EMPTY, 50, 32'd1, 1'b1);
        // flush in the middle of a sample; the outermost span saturates
        push_req(REQ_FRAME, 60, 32'h0000_0000, 1'b0);
        push_req(REQ_FRAME, rand_stamp(), 32'd9, 1'b0);
        push_req(REQ_FLUSH, rand_stamp(), 32'd2, 1'b0);
        // big jump in time, then a zero-length segment
        push_req(REQ_FRAME, TS_BASE, 32'd3, 1'b1);
        push_req(REQ_FLUSH, rand_stamp(), 32'd4, 1'b1);
        drain();

        now_stamp = TS_BASE;
        stack_len = 0;

        // ---- pressure: long receiver hold while a full-depth stack unwinds ----
        pace = PACE_STEADY;
        hold_request = 1'b1;
        for (i = 0; i < MAX_DEPTH; i++)
            stack_ids[i] = pick_id();
        stack_len = MAX_DEPTH;
        send_stack(1'b1);
        stack_ids[0] = ~stack_ids[0];
        stack_len = 1;
        send_stack(1'b1);
        run_phase(PACE_STEADY);

        // ---- random phases under each pacing ----
        run_phase(PACE_SENDER_GAPS);
        run_phase(PACE_RECEIVER_STALLS);
        run_phase(PACE_BOTH);
        run_phase(PACE_STEADY);

        // ---- closing error, which halts the block for good ----
        pace = PACE_BOTH;
        push_req(REQ_EMPTY, TS_MAX, pick_id(), 1'b0);
        if ($urandom_range(0, 1) == 1)
        begin
            // one frame past the deepest allowed level
            for (i = 0; i <= MAX_DEPTH; i++)
                push_req(REQ_FRAME, (i == 0) ? TS_MAX : rand_stamp(), pick_id(),
                         i == MAX_DEPTH);
        end
        else
        begin
            push_req(($urandom_range(0, 1) == 1) ? REQ_FRAME : REQ_EMPTY,
                     TS_MAX - TS_W'($urandom_range(1, 1000)), pick_id(), 1'b1);
        end
        // halted: all of these are dropped
        push_req(REQ_FRAME, rand_stamp(), pick_id(), 1'b1);
        push_req(REQ_FLUSH, rand_stamp(), pick_id(), 1'b0);
        push_req(REQ_EMPTY, TS_MIN, pick_id(), 1'b1);

        in_valid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && backlog == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
